FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the alarm table scheduler (used by alarm_table_scheduler).
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ATS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ats_pkg.sv
// Shared types and constants of the alarm table scheduler.
// Used by ats_ctrl, ats_dp, alarm_table_scheduler and the sim files; no dependencies.
`default_nettype none

package ats_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int IN_W        = 90;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 72;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 7;

  localparam logic [7:0]  MAX_HOUR   = 8'd23;
  localparam logic [7:0]  MAX_MINUTE = 8'd59;
  localparam logic [31:0] BUZZ_LIMIT_RST = 32'd60000;
  localparam logic [31:0] SNOOZE_RST     = 32'd300000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE_LEN = 1'b1;

  // Request codes
  localparam logic [3:0] REQ_TICK    = 4'd0;
  localparam logic [3:0] REQ_ADD_REP = 4'd1;
  localparam logic [3:0] REQ_ADD_ONE = 4'd2;
  localparam logic [3:0] REQ_REMOVE  = 4'd3;
  localparam logic [3:0] REQ_ENABLE  = 4'd4;
  localparam logic [3:0] REQ_MODIFY  = 4'd5;
  localparam logic [3:0] REQ_SNOOZE  = 4'd6;
  localparam logic [3:0] REQ_DISMISS = 4'd7;
  localparam logic [3:0] REQ_CLEAR   = 4'd8;
  localparam logic [3:0] REQ_READ    = 4'd9;

  typedef enum logic [1:0] {
    AS_IDLE   = 2'd0,
    AS_TRIG   = 2'd1,
    AS_SNOOZE = 2'd2,
    AS_WAIT   = 2'd3
  } alarm_state_t;

  typedef enum logic [1:0] {
    CS_IDLE    = 2'd0,
    CS_SCAN    = 2'd1,
    CS_COMPACT = 2'd2,
    CS_EXEC    = 2'd3
  } ctl_state_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  mask;
    logic        en;
    logic        rep;
    logic [15:0] date;
  } entry_t;

  // Input item, last field in the low bits
  typedef struct packed {
    logic        enable_flag;
    logic [7:0]  alarm_id;
    logic [15:0] date_day;
    logic [7:0]  day_mask;
    logic [2:0]  weekday;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic        pill_box_open;
    logic        rtc_valid;
    logic [31:0] now_ms;
    logic [3:0]  req_type;
  } in_item_t;

  // Result item, last field in the low bits
  typedef struct packed {
    logic               rd_repeating;
    logic               rd_enabled;
    logic [7:0]         rd_day_mask;
    logic [5:0]         rd_minute;
    logic [4:0]         rd_hour;
    logic [COUNT_W-1:0] alarm_count;
    logic [31:0]        elapsed_ms;
    logic               buzzer_on;
    logic [7:0]         active_id;
    logic [1:0]         alarm_state;
    logic               ok;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic compact;
    logic exec;
  } ats_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic is_remove;
    logic compact_end;
    logic out_free;
  } ats_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ats_ctrl.sv
// Sequencer of the alarm table scheduler: accept, table scan, compaction, execute.
// Depends on ats_pkg.
`default_nettype none

module ats_ctrl import ats_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_tvalid,
  output logic     in_tready,
  input  ats_sts_t sts,
  output ats_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_tvalid) state_nxt = CS_SCAN;
      end
      CS_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = CS_EXEC;
        end else if (sts.hit) begin
          state_nxt = sts.is_remove ? CS_COMPACT : CS_EXEC;
        end
      end
      CS_COMPACT: begin
        if (sts.compact_end) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        if (sts.out_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      CS_SCAN:    cmd.scan    = 1'b1;
      CS_COMPACT: cmd.compact = 1'b1;
      CS_EXEC:    cmd.exec    = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ats_dp.sv
// Datapath of the alarm table scheduler: alarm table, scan index, alarm
// state registers, config registers and the result register. Depends on ats_pkg.
`default_nettype none

module ats_dp import ats_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire  [IN_TDATA_W-1:0]  in_tdata,
  input  wire                    out_tready,
  input  ats_cmd_t               cmd,
  output ats_sts_t               sts,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [31:0]        limit_r, snooze_r;
  in_item_t           in_r;
  entry_t             tbl_r [TABLE_DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r;
  logic               hit_r;
  alarm_state_t       ast_r, ast_nxt;
  logic [7:0]         sid_r, sid_nxt;
  logic [31:0]        tstart_r, tstart_nxt;
  logic [31:0]        sstart_r, sstart_nxt;
  logic               buzz_r, buzz_nxt;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  // single read port: next entry while compacting, current entry otherwise
  logic [CNT_W-1:0]   idx_p1;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_e;
  logic               match, time_ok, slot_hit;
  logic [31:0]        diff_t, diff_s;

  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_wa;
  entry_t             tbl_wd;

  assign idx_p1  = idx_r + CNT_W'(1);
  assign rd_addr = cmd.compact ? idx_p1[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign rd_e    = tbl_r[rd_addr];

  // match: ticks need an enabled entry, time, then one-time date or weekday mask; other requests match by id
  always_comb begin
    slot_hit = (in_r.hour == {3'b000, rd_e.hour}) && (in_r.minute == {2'b00, rd_e.minute});
    if (!rd_e.rep) begin
      slot_hit = slot_hit && (in_r.date_day == rd_e.date);
    end else if (rd_e.mask != 8'd0) begin
      slot_hit = slot_hit && rd_e.mask[in_r.weekday];
    end
    if (in_r.req_type == REQ_TICK) begin
      match = rd_e.en && slot_hit;
    end else begin
      match = (rd_e.id == in_r.alarm_id);
    end
  end

  assign time_ok = (in_r.hour <= MAX_HOUR) && (in_r.minute <= MAX_MINUTE);
  assign diff_t  = in_r.now_ms - tstart_r;
  assign diff_s  = in_r.now_ms - sstart_r;

  assign sts.scan_end    = (idx_r >= cnt_r);
  assign sts.hit         = match;
  assign sts.is_remove   = (in_r.req_type == REQ_REMOVE);
  assign sts.compact_end = (idx_p1 >= cnt_r);
  assign sts.out_free    = !out_valid_r || out_tready;

  // request execution
  always_comb begin
    cnt_nxt    = cnt_r;
    ast_nxt    = ast_r;
    sid_nxt    = sid_r;
    tstart_nxt = tstart_r;
    sstart_nxt = sstart_r;
    buzz_nxt   = buzz_r;
    tbl_we     = 1'b0;
    tbl_wa     = idx_r[IDX_W-1:0];
    tbl_wd     = rd_e;
    out_nxt    = '0;

    if (cmd.compact && !sts.compact_end) begin
      tbl_we = 1'b1;
    end

    // elapsed follows the start time: unchanged start -> diff_t
    out_nxt.elapsed_ms = diff_t;

    case (in_r.req_type)
      REQ_TICK: begin
        out_nxt.ok = in_r.rtc_valid;
        if (in_r.rtc_valid) begin
          case (ast_r)
            AS_IDLE: begin
              if (hit_r) begin
                ast_nxt            = AS_TRIG;
                sid_nxt            = rd_e.id;
                tstart_nxt         = in_r.now_ms;
                buzz_nxt           = 1'b1;
                out_nxt.elapsed_ms = 32'd0;
              end
            end
            AS_TRIG: begin
              if (in_r.pill_box_open) begin
                ast_nxt            = AS_WAIT;
                sid_nxt            = 8'd0;
                tstart_nxt         = 32'd0;
                buzz_nxt           = 1'b0;
                out_nxt.elapsed_ms = in_r.now_ms;
              end else if (diff_t >= limit_r) begin
                ast_nxt    = AS_IDLE;
                sid_nxt    = 8'd0;
                tstart_nxt = 32'd0;
                buzz_nxt   = 1'b0;
              end else begin
                buzz_nxt = 1'b1;
              end
            end
            AS_SNOOZE: begin
              if (diff_s >= snooze_r) begin
                ast_nxt            = AS_TRIG;
                tstart_nxt         = in_r.now_ms;
                out_nxt.elapsed_ms = 32'd0;
              end
            end
            AS_WAIT: begin
              if (!in_r.pill_box_open) begin
                ast_nxt = AS_IDLE;
                sid_nxt = 8'd0;
              end
            end
            default: ast_nxt = AS_IDLE;
          endcase
        end
      end
      REQ_ADD_REP, REQ_ADD_ONE: begin
        if ((cnt_r < CNT_W'(TABLE_DEPTH)) && time_ok) begin
          out_nxt.ok    = 1'b1;
          tbl_we        = cmd.exec;
          tbl_wa        = cnt_r[IDX_W-1:0];
          tbl_wd.id     = 8'(cnt_r) + 8'd1;
          tbl_wd.hour   = in_r.hour[4:0];
          tbl_wd.minute = in_r.minute[5:0];
          tbl_wd.en     = 1'b1;
          if (in_r.req_type == REQ_ADD_REP) begin
            tbl_wd.rep  = 1'b1;
            tbl_wd.mask = in_r.day_mask;
            tbl_wd.date = 16'd0;
          end else begin
            tbl_wd.rep  = 1'b0;
            tbl_wd.mask = 8'd0;
            tbl_wd.date = in_r.date_day;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (hit_r) begin
          out_nxt.ok = 1'b1;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end
      end
      REQ_ENABLE: begin
        if (hit_r) begin
          out_nxt.ok = 1'b1;
          tbl_we     = cmd.exec;
          tbl_wd.en  = in_r.enable_flag;
        end
      end
      REQ_MODIFY: begin
        if (hit_r && time_ok) begin
          out_nxt.ok    = 1'b1;
          tbl_we        = cmd.exec;
          tbl_wd.hour   = in_r.hour[4:0];
          tbl_wd.minute = in_r.minute[5:0];
          tbl_wd.mask   = in_r.day_mask;
        end
      end
      REQ_SNOOZE: begin
        if (ast_r == AS_TRIG) begin
          out_nxt.ok = 1'b1;
          ast_nxt    = AS_SNOOZE;
          sstart_nxt = in_r.now_ms;
          buzz_nxt   = 1'b0;
        end
      end
      REQ_DISMISS: begin
        out_nxt.ok = 1'b1;
        ast_nxt    = AS_IDLE;
        sid_nxt    = 8'd0;
        tstart_nxt = 32'd0;
        buzz_nxt   = 1'b0;
      end
      REQ_CLEAR: begin
        out_nxt.ok = 1'b1;
        cnt_nxt    = '0;
      end
      REQ_READ: begin
        if (hit_r) begin
          out_nxt.ok           = 1'b1;
          out_nxt.rd_hour      = rd_e.hour;
          out_nxt.rd_minute    = rd_e.minute;
          out_nxt.rd_day_mask  = rd_e.mask;
          out_nxt.rd_enabled   = rd_e.en;
          out_nxt.rd_repeating = rd_e.rep;
        end
      end
      default: out_nxt.ok = 1'b0;
    endcase

    if ((ast_nxt != AS_TRIG) && (ast_nxt != AS_WAIT)) begin
      out_nxt.elapsed_ms = 32'd0;
    end
    out_nxt.alarm_state = ast_nxt;
    out_nxt.active_id   = sid_nxt;
    out_nxt.buzzer_on   = buzz_nxt;
    out_nxt.alarm_count = COUNT_W'(cnt_nxt);
  end

  // table: no reset, entries at or above the count are never used
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_r[tbl_wa] <= tbl_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_item_t'(in_tdata[IN_W-1:0]);
    if (cmd.exec) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= BUZZ_LIMIT_RST;
      snooze_r    <= SNOOZE_RST;
      cnt_r       <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      ast_r       <= AS_IDLE;
      sid_r       <= 8'd0;
      tstart_r    <= 32'd0;
      sstart_r    <= 32'd0;
      buzz_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUZZ_LIMIT: limit_r  <= cfg_wdata;
          CFG_SNOOZE_LEN: snooze_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.scan && !sts.scan_end) begin
        if (match) hit_r <= 1'b1;
        else       idx_r <= idx_p1;
      end else if (cmd.compact && !sts.compact_end) begin
        idx_r <= idx_p1;
      end
      if (cmd.exec) begin
        cnt_r       <= cnt_nxt;
        ast_r       <= ast_nxt;
        sid_r       <= sid_nxt;
        tstart_r    <= tstart_nxt;
        sstart_r    <= sstart_nxt;
        buzz_r      <= buzz_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

endmodule

`default_nettype wire

FILE: rtl/alarm_table_scheduler.sv
// Alarm table scheduler: one result item per request item. Each item passes an
// accept step, a one-entry-per-cycle table scan, a one-entry-per-cycle
// compaction on remove, and an execute step that loads the result register
// once that register is free. The result is valid in the cycle after the
// execute step and waits there.
// Reset (rst_n low, synchronous) empties the table and idles the alarm.
`default_nettype none
`include "assert_macros.svh"

module alarm_table_scheduler import ats_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  // Configuration write port
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,   // 0 buzz_limit_ms, 1 snooze_length_ms
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata,
  // Request items
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // req_type[3:0], now_ms[35:4], rtc_valid[36], pill_box_open[37], hour[45:38],
  // minute[53:46], weekday[56:54], day_mask[64:57], date_day[80:65],
  // alarm_id[88:81], enable_flag[89], zero pad above
  input  wire  [IN_TDATA_W-1:0]  in_tdata,
  // Result items
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // ok[0], alarm_state[2:1], active_id[10:3], buzzer_on[11], elapsed_ms[43:12],
  // alarm_count[50:44], rd_hour[55:51], rd_minute[61:56], rd_day_mask[69:62],
  // rd_enabled[70], rd_repeating[71]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ats_cmd_t cmd;
  ats_sts_t sts;

  // Sequencer: walks each item through scan, optional compaction and execute.
  ats_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: table, alarm state, timers, config and result register.
  ats_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // Result view for the checks below
  out_item_t res;
  assign res = out_item_t'(out_tdata[OUT_W-1:0]);

  // Buzzer only sounds while triggered
  `ATS_ASSERT_NOW(a_buzz_trig, out_tvalid && res.buzzer_on, res.alarm_state == AS_TRIG, "buzzer on outside triggered state")
  // An active id exists only while triggered or snoozed
  `ATS_ASSERT_NOW(a_id_state, out_tvalid && (res.active_id != 8'd0), (res.alarm_state == AS_TRIG) || (res.alarm_state == AS_SNOOZE), "active id in wrong state")
  // Elapsed time is reported only while triggered or waiting
  `ATS_ASSERT_NOW(a_elapsed, out_tvalid && (res.elapsed_ms != 32'd0), (res.alarm_state == AS_TRIG) || (res.alarm_state == AS_WAIT), "elapsed time in wrong state")
  // Table never overfills
  `ATS_ASSERT_NOW(a_count, out_tvalid, res.alarm_count <= COUNT_W'(TABLE_DEPTH), "table count above depth")
  // One item in flight: no acceptance right after an acceptance
  `ATS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "item accepted while busy")

endmodule

`default_nettype wire

FILE: sim/alarm_table_checker.sv
// Scoreboard for the alarm table scheduler: keeps its own alarm table and
// alarm state, predicts one result item per accepted request item and
// compares it with the output stream. Depends on ats_pkg.
module alarm_table_checker import ats_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count
);

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  mask;
    logic        en;
    logic        rep;
    logic [15:0] date;
  } alarm_slot_t;

  alarm_slot_t  slots [TABLE_DEPTH];
  int           n_slots;
  alarm_state_t st;
  logic [7:0]   ring_id;
  logic [31:0]  ring_start;
  logic [31:0]  snooze_start;
  logic [31:0]  limit_ms;
  logic [31:0]  snooze_ms;
  logic         buzzing;
  out_item_t    responses_due [$];
  out_item_t    got_resp;
  out_item_t    want_resp;
  int           bad_items = 0;

  initial fail_count = 0;

  // first entry with this id, -1 if none
  function automatic int find_slot(logic [7:0] id);
    int i;
    int k;
    k = -1;
    for (i = n_slots - 1; i >= 0; i--)
      if (slots[i].id == id) k = i;
    return k;
  endfunction

  function automatic bit slot_due(alarm_slot_t s, in_item_t rq);
    if (rq.hour != s.hour || rq.minute != s.minute) return 1'b0;
    if (!s.rep) return rq.date_day == s.date;
    if (s.mask == 8'h00) return 1'b1;
    return s.mask[rq.weekday];
  endfunction

  function automatic void stop_alarm();
    st = AS_IDLE;
    buzzing = 1'b0;
    ring_id = 8'd0;
    ring_start = 32'd0;
  endfunction

  function automatic bit add_slot(in_item_t rq, bit rep);
    if (n_slots >= TABLE_DEPTH || rq.hour > MAX_HOUR || rq.minute > MAX_MINUTE)
      return 1'b0;
    slots[n_slots].id     = 8'(n_slots + 1);
    slots[n_slots].hour   = rq.hour;
    slots[n_slots].minute = rq.minute;
    slots[n_slots].mask   = rep ? rq.day_mask : 8'h00;
    slots[n_slots].en     = 1'b1;
    slots[n_slots].rep    = rep;
    slots[n_slots].date   = rep ? 16'd0 : rq.date_day;
    n_slots++;
    return 1'b1;
  endfunction

  function automatic void run_tick(in_item_t rq);
    int i;
    int hit;
    logic [31:0] dt;
    case (st)
      AS_IDLE: begin
        hit = -1;
        for (i = n_slots - 1; i >= 0; i--)
          if (slots[i].en && slot_due(slots[i], rq)) hit = i;
        if (hit >= 0) begin
          st = AS_TRIG;
          ring_id = slots[hit].id;
          ring_start = rq.now_ms;
          buzzing = 1'b1;
        end
      end
      AS_TRIG: begin
        dt = rq.now_ms - ring_start;
        if (rq.pill_box_open) begin
          stop_alarm();
          st = AS_WAIT;
        end else if (dt >= limit_ms) begin
          stop_alarm();
        end else begin
          buzzing = 1'b1;
        end
      end
      AS_SNOOZE: begin
        dt = rq.now_ms - snooze_start;
        // buzzer stays off until the next tick in triggered state
        if (dt >= snooze_ms) begin
          st = AS_TRIG;
          ring_start = rq.now_ms;
        end
      end
      default: begin
        if (!rq.pill_box_open) begin
          st = AS_IDLE;
          ring_id = 8'd0;
        end
      end
    endcase
  endfunction

  function automatic out_item_t alarm_response(in_item_t rq);
    out_item_t res;
    int k;
    int i;
    res = '0;
    case (rq.req_type)
      REQ_TICK: begin
        if (rq.rtc_valid) begin
          run_tick(rq);
          res.ok = 1'b1;
        end
      end
      REQ_ADD_REP: res.ok = add_slot(rq, 1'b1);
      REQ_ADD_ONE: res.ok = add_slot(rq, 1'b0);
      REQ_REMOVE: begin
        k = find_slot(rq.alarm_id);
        if (k >= 0) begin
          for (i = k; i + 1 < n_slots; i++) slots[i] = slots[i + 1];
          n_slots--;
          res.ok = 1'b1;
        end
      end
      REQ_ENABLE: begin
        k = find_slot(rq.alarm_id);
        if (k >= 0) begin
          slots[k].en = rq.enable_flag;
          res.ok = 1'b1;
        end
      end
      REQ_MODIFY: begin
        if (rq.hour <= MAX_HOUR && rq.minute <= MAX_MINUTE) begin
          k = find_slot(rq.alarm_id);
          if (k >= 0) begin
            slots[k].hour = rq.hour;
            slots[k].minute = rq.minute;
            slots[k].mask = rq.day_mask;
            res.ok = 1'b1;
          end
        end
      end
      REQ_SNOOZE: begin
        if (st == AS_TRIG) begin
          st = AS_SNOOZE;
          snooze_start = rq.now_ms;
          buzzing = 1'b0;
          res.ok = 1'b1;
        end
      end
      REQ_DISMISS: begin
        stop_alarm();
        res.ok = 1'b1;
      end
      REQ_CLEAR: begin
        n_slots = 0;
        res.ok = 1'b1;
      end
      REQ_READ: begin
        k = find_slot(rq.alarm_id);
        if (k >= 0) begin
          res.ok = 1'b1;
          res.rd_hour = slots[k].hour[4:0];
          res.rd_minute = slots[k].minute[5:0];
          res.rd_day_mask = slots[k].mask;
          res.rd_enabled = slots[k].en;
          res.rd_repeating = slots[k].rep;
        end
      end
      default: ;
    endcase
    res.alarm_state = st;
    res.active_id = ring_id;
    res.buzzer_on = buzzing;
    res.elapsed_ms = (st == AS_TRIG || st == AS_WAIT) ? rq.now_ms - ring_start : 32'd0;
    res.alarm_count = COUNT_W'(n_slots);
    return res;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got,
                                  bit loud);
    if (want === got) return 1'b1;
    if (loud)
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  function automatic bit same_response(out_item_t want, out_item_t got);
    bit loud;
    bit good;
    loud = bad_items < 10;
    good = 1'b1;
    good &= field_ok("ok", want.ok, got.ok, loud);
    good &= field_ok("alarm_state", want.alarm_state, got.alarm_state, loud);
    good &= field_ok("active_id", want.active_id, got.active_id, loud);
    good &= field_ok("buzzer_on", want.buzzer_on, got.buzzer_on, loud);
    good &= field_ok("elapsed_ms", want.elapsed_ms, got.elapsed_ms, loud);
    good &= field_ok("alarm_count", want.alarm_count, got.alarm_count, loud);
    good &= field_ok("rd_hour", want.rd_hour, got.rd_hour, loud);
    good &= field_ok("rd_minute", want.rd_minute, got.rd_minute, loud);
    good &= field_ok("rd_day_mask", want.rd_day_mask, got.rd_day_mask, loud);
    good &= field_ok("rd_enabled", want.rd_enabled, got.rd_enabled, loud);
    good &= field_ok("rd_repeating", want.rd_repeating, got.rd_repeating, loud);
    return good;
  endfunction

  // results leave before new requests are taken in on the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      n_slots = 0;
      st = AS_IDLE;
      ring_id = 8'd0;
      ring_start = 32'd0;
      snooze_start = 32'd0;
      buzzing = 1'b0;
      limit_ms = BUZZ_LIMIT_RST;
      snooze_ms = SNOOZE_RST;
      responses_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_resp = out_tdata[OUT_W-1:0];
        if (responses_due.size() == 0) begin
          if (bad_items < 10)
            $display("%0t: result item with none pending: expected nothing, got %0h",
                     $time, got_resp);
          bad_items++;
        end else begin
          want_resp = responses_due.pop_front();
          if (!same_response(want_resp, got_resp)) bad_items++;
        end
      end
      if (in_tvalid && in_tready)
        responses_due.push_back(alarm_response(in_tdata[IN_W-1:0]));
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUZZ_LIMIT: limit_ms = cfg_wdata;
          CFG_SNOOZE_LEN: snooze_ms = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= bad_items + responses_due.size();
  end

endmodule

FILE: sim/tb_alarm_table_scheduler.sv
// Testbench top for alarm_table_scheduler: clock, reset, request stimulus,
// random back-pressure on both streams and the final verdict.
// Depends on ats_pkg, the block itself and alarm_table_checker.
module tb_alarm_table_scheduler;
  import ats_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int N_SEGMENTS  = 6;
  localparam int SEG_ITEMS   = 88;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;

  int          send_gap_pct = 0;   // chance of a sender gap before an item
  int          recv_gap_pct = 0;   // chance the receiver stalls in a cycle
  int unsigned n_sent = 0;
  int unsigned n_done = 0;
  int unsigned quiet_cycles = 0;

  // stimulus-side wall clock and the last alarm time added, so that ticks
  // often land on a time that is in the table
  logic [31:0] now_q = 32'd1000;
  logic [7:0]  last_hour = 8'd7;
  logic [7:0]  last_minute = 8'd30;
  logic [15:0] last_date = 16'd100;

  alarm_table_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  alarm_table_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls at the current rate, none when the rate is 0
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) n_done <= n_done + 1;
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t tick_item(logic rtc, logic box, logic [7:0] hr,
                                         logic [7:0] mn, logic [2:0] wd,
                                         logic [15:0] day);
    in_item_t it;
    it = '0;
    it.req_type = REQ_TICK;
    it.now_ms = now_q;
    it.rtc_valid = rtc;
    it.pill_box_open = box;
    it.hour = hr;
    it.minute = mn;
    it.weekday = wd;
    it.date_day = day;
    return it;
  endfunction

  function automatic in_item_t cmd_item(logic [3:0] req, logic [7:0] hr,
                                        logic [7:0] mn, logic [7:0] mask,
                                        logic [15:0] day, logic [7:0] id,
                                        logic en);
    in_item_t it;
    it = '0;
    it.req_type = req;
    it.now_ms = now_q;
    it.hour = hr;
    it.minute = mn;
    it.day_mask = mask;
    it.date_day = day;
    it.alarm_id = id;
    it.enable_flag = en;
    return it;
  endfunction

  // Random request: every field starts as random bits, then the fields
  // that steer the behavior are pulled toward useful values.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [95:0] raw;
    int unsigned roll;
    raw = {$urandom, $urandom, $urandom};
    it = raw[IN_W-1:0];

    roll = $urandom_range(99);
    if (roll < 45)      it.req_type = REQ_TICK;
    else if (roll < 55) it.req_type = REQ_ADD_REP;
    else if (roll < 61) it.req_type = REQ_ADD_ONE;
    else if (roll < 67) it.req_type = REQ_REMOVE;
    else if (roll < 72) it.req_type = REQ_ENABLE;
    else if (roll < 77) it.req_type = REQ_MODIFY;
    else if (roll < 85) it.req_type = REQ_SNOOZE;
    else if (roll < 88) it.req_type = REQ_DISMISS;
    else if (roll < 90) it.req_type = REQ_CLEAR;
    else if (roll < 98) it.req_type = REQ_READ;
    else                it.req_type = REQ_READ + 4'(1 + $urandom_range(5));

    // mostly short steps, some past the buzz and snooze limits, rare jumps
    roll = $urandom_range(99);
    if (roll < 60)      now_q = now_q + $urandom_range(300);
    else if (roll < 88) now_q = now_q + $urandom_range(70000);
    else if (roll < 96) now_q = now_q + $urandom_range(400000);
    else                now_q = $urandom;
    it.now_ms = now_q;

    it.rtc_valid = ($urandom_range(9) != 0);
    it.pill_box_open = ($urandom_range(3) == 0);
    if ($urandom_range(4) != 0) begin
      case ($urandom_range(3))
        0, 1: begin
          it.hour = last_hour;
          it.minute = last_minute;
        end
        2: begin
          it.hour = 8'd0;
          it.minute = 8'd0;
        end
        default: begin
          it.hour = MAX_HOUR;
          it.minute = MAX_MINUTE;
        end
      endcase
    end
    if ($urandom_range(4) != 0) it.date_day = last_date;
    if ($urandom_range(2) == 0) it.day_mask = 8'h00;
    if ($urandom_range(6) != 0) it.alarm_id = 8'($urandom_range(9));

    if ((it.req_type == REQ_ADD_REP || it.req_type == REQ_ADD_ONE) &&
        it.hour <= MAX_HOUR && it.minute <= MAX_MINUTE) begin
      last_hour = it.hour;
      last_minute = it.minute;
      if (it.req_type == REQ_ADD_ONE) last_date = it.date_day;
    end
    return it;
  endfunction

  // Valid stays up after an accepted item unless a gap or a drain follows,
  // so back-to-back items never see valid dropped and raised in one step.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tdata <= IN_TDATA_W'(it);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain();
    if (n_done != n_sent) begin
      in_tvalid <= 1'b0;
      while (n_done != n_sent) @(posedge clk);
    end
  endtask

  task automatic set_timing(input logic [31:0] limit_val, input logic [31:0] snooze_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BUZZ_LIMIT;
    cfg_wdata <= limit_val;
    @(posedge clk);
    cfg_index <= CFG_SNOOZE_LEN;
    cfg_wdata <= snooze_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BUZZ_LIMIT;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset timing (60 s buzz, 300 s snooze).
    send_item(tick_item(0, 0, 7, 30, 3, 100));              // no wall clock
    send_item(cmd_item(REQ_READ, 0, 0, 0, 0, 1, 0));         // empty table
    send_item(cmd_item(REQ_ADD_REP, 24, 0, 0, 0, 0, 0));     // bad hour
    send_item(cmd_item(REQ_ADD_REP, 7, 30, 8'h00, 0, 0, 0)); // id 1, daily
    send_item(cmd_item(REQ_ADD_ONE, 23, 59, 8'hFF, 16'hFFFF, 0, 0)); // id 2
    send_item(cmd_item(REQ_ADD_REP, 0, 0, 8'h80, 0, 0, 0));  // id 3, weekday 7 bit
    send_item(cmd_item(REQ_READ, 0, 0, 0, 0, 2, 0));
    send_item(tick_item(1, 0, 7, 30, 3, 100));               // triggers id 1
    now_q = now_q + 100;
    send_item(tick_item(1, 0, 7, 31, 3, 100));               // still sounding
    now_q = now_q + 100;
    send_item(cmd_item(REQ_SNOOZE, 0, 0, 0, 0, 0, 0));
    now_q = now_q + 32'd300000;
    send_item(tick_item(1, 0, 7, 31, 3, 100));               // snooze over
    now_q = now_q + 10;
    send_item(tick_item(1, 0, 7, 31, 3, 100));               // buzzer back on
    now_q = now_q + 10;
    send_item(tick_item(1, 1, 7, 31, 3, 100));               // lid opens
    send_item(tick_item(1, 0, 7, 31, 3, 100));               // lid closed
    send_item(tick_item(1, 0, 23, 59, 6, 16'hFFFF));         // one-time id 2
    now_q = now_q + 32'd60000;
    send_item(tick_item(1, 0, 23, 59, 6, 16'hFFFF));         // buzz timeout
    send_item(cmd_item(REQ_SNOOZE, 0, 0, 0, 0, 0, 0));       // nothing sounding
    send_item(tick_item(1, 0, 0, 0, 7, 0));                  // weekday 7 match
    send_item(cmd_item(REQ_DISMISS, 0, 0, 0, 0, 0, 0));
    send_item(cmd_item(REQ_ENABLE, 0, 0, 0, 0, 3, 0));
    send_item(cmd_item(REQ_MODIFY, 255, 0, 0, 0, 1, 0));     // bad time
    send_item(cmd_item(REQ_MODIFY, 6, 0, 8'hFF, 0, 1, 0));
    send_item(cmd_item(REQ_REMOVE, 0, 0, 0, 0, 1, 0));       // entries move down
    send_item(cmd_item(REQ_READ + 4'd6, 0, 0, 0, 0, 0, 0));  // unknown request
    send_item(cmd_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0));

    // Random part: timing changes only with the block drained.
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      drain();
      case (seg)
        0: set_timing(32'd100, 32'd250);
        1: set_timing(32'd0, 32'd0);
        2: set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_timing(32'd5000, 32'd1);
        4: set_timing(32'd1, 32'hFFFF_FFFF);
        default: set_timing(BUZZ_LIMIT_RST, SNOOZE_RST);
      endcase
      // light sender gaps with heavy stalls, then the reverse, then none
      send_gap_pct = (seg < 2) ? 16 : (seg < 4) ? 45 : 0;
      recv_gap_pct = (seg < 2) ? 45 : (seg < 4) ? 16 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(59) == 0) drain();
        send_item(random_item());
      end
    end

    drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
